// ===== src/cnad_pkg.sv =====
`timescale 1ns / 1ps
package cnad_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Configuration register indexes
  localparam logic CFG_EMIT_NAMES = 1'b0;
  localparam logic CFG_EMIT_DATA  = 1'b1;

  // newc header layout
  localparam logic [31:0] HDR_LEN     = 32'd110;
  localparam logic [31:0] MAGIC_LEN   = 32'd6;
  localparam logic [31:0] FSIZE_FIRST = 32'd54;
  localparam logic [31:0] FSIZE_LAST  = 32'd61;
  localparam logic [31:0] NSIZE_FIRST = 32'd94;
  localparam logic [31:0] NSIZE_LAST  = 32'd101;
  localparam logic [31:0] TRAILER_LEN = 32'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // "070701"
  function automatic logic [7:0] magic_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1, 3'd3: c = 8'h37;
      3'd5:       c = 8'h31;
      default:    c = 8'h30;
    endcase
    return c;
  endfunction

  // "TRAILER!!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

endpackage

// ===== src/cnad_if.sv =====
`timescale 1ns / 1ps
interface cnad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cnad_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        last_of_part;
  logic [15:0] entry_number;
  logic [31:0] size_of_file;
  logic [31:0] size_of_name;

  modport source (output valid, output out_kind, output out_byte, output last_of_part,
                  output entry_number, output size_of_file, output size_of_name,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last_of_part,
                  input entry_number, input size_of_file, input size_of_name,
                  output ready);
endinterface

// ===== src/cpio_newc_archive_deframer.sv =====
`timescale 1ns / 1ps
// newc cpio archive deframer.
// in_ch carries the archive one byte per item (valid/ready). out_ch carries
// name bytes, data bytes, an end-of-archive marker or a format error, each
// tagged with the entry number and the parsed sizes of the current entry.
// Header bytes produce no item unless one raises a format error; padding none.
// A byte that produces a result shows it on out_ch in the cycle after it is
// accepted. Throughput: one byte per cycle while in_ch is ready; the whole
// parse step sits between the accepting edge and the output register.
// When the receiver stalls, the output register holds its item and in_ch
// accepts no byte; in_ch is ready only while the output register is empty
// or is emptied in the same cycle.
// Reset (rst_n low, synchronous) returns to the start of a header, clears
// the entry counter and stream alignment and sets emit_names and emit_data.
// After the end marker or an error the block swallows all further bytes
// until reset. cfg_we writes register cfg_index (0 emit_names, 1 emit_data).
module cpio_newc_archive_deframer
  import cnad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cnad_in_if.sink     in_ch,
  cnad_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_NAME     = 3'd1,
    PH_NAME_PAD = 3'd2,
    PH_DATA     = 3'd3,
    PH_DATA_PAD = 3'd4,
    PH_DONE     = 3'd5,
    PH_ERROR    = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] part_cnt_r, part_cnt_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [31:0] fsz_r, fsz_nxt;
  logic [31:0] nsz_r, nsz_nxt;
  logic        tmatch_r, tmatch_nxt;
  logic [15:0] entry_r, entry_nxt;
  logic        emit_names_r, emit_data_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [15:0] out_entry_r;
  logic [31:0] out_fsz_r, out_nsz_r;

  logic        in_acc;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [7:0]  b;
  logic [31:0] idx;
  hex_digit_t  hx;
  logic        name_last, data_last;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign idx         = part_cnt_r;
  assign hx          = hex_decode(b);
  assign name_last   = (idx == nsz_r - 32'd1);
  assign data_last   = (idx == fsz_r - 32'd1);

  always_comb begin
    phase_nxt    = phase_r;
    part_cnt_nxt = part_cnt_r;
    off_nxt      = off_r;
    fsz_nxt      = fsz_r;
    nsz_nxt      = nsz_r;
    tmatch_nxt   = tmatch_r;
    entry_nxt    = entry_r;
    res_valid    = 1'b0;
    res_kind     = KIND_NAME;
    res_byte     = 8'd0;
    res_last     = 1'b0;
    if (in_acc) begin
      off_nxt = off_r + 2'd1;
      unique case (phase_r)
        PH_HEADER: begin
          if (idx == 32'd0) begin
            fsz_nxt    = 32'd0;
            nsz_nxt    = 32'd0;
            tmatch_nxt = 1'b1;
          end
          if (idx < MAGIC_LEN && b != magic_char(idx[2:0])) begin
            res_valid = 1'b1;
            res_kind  = KIND_ERROR;
            phase_nxt = PH_ERROR;
          end else if ((idx >= FSIZE_FIRST && idx <= FSIZE_LAST) ||
                       (idx >= NSIZE_FIRST && idx <= NSIZE_LAST)) begin
            if (!hx.ok) begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              phase_nxt = PH_ERROR;
            end else if (idx <= FSIZE_LAST) begin
              fsz_nxt = {fsz_nxt[27:0], hx.val};
            end else begin
              nsz_nxt = {nsz_nxt[27:0], hx.val};
            end
          end
          if (!res_valid) begin
            part_cnt_nxt = idx + 32'd1;
            if (idx == HDR_LEN - 32'd1) begin
              part_cnt_nxt = 32'd0;
              if (nsz_nxt != 32'd0) begin
                phase_nxt = PH_NAME;
              end else if (off_nxt != 2'd0) begin
                phase_nxt = PH_NAME_PAD;
              end else if (fsz_nxt != 32'd0) begin
                phase_nxt = PH_DATA;
              end else begin
                entry_nxt = entry_r + 16'd1;
              end
            end
          end
        end
        PH_NAME: begin
          if (idx < TRAILER_LEN && b != trailer_char(idx[3:0])) begin
            tmatch_nxt = 1'b0;
          end
          if (idx == TRAILER_LEN - 32'd1 && tmatch_nxt) begin
            // trailer name completes on this byte: end of archive
            res_valid = 1'b1;
            res_kind  = KIND_END;
            phase_nxt = PH_DONE;
          end else begin
            res_valid    = emit_names_r;
            res_kind     = KIND_NAME;
            res_byte     = b;
            res_last     = name_last;
            part_cnt_nxt = idx + 32'd1;
            if (name_last) begin
              if (off_nxt != 2'd0) begin
                phase_nxt = PH_NAME_PAD;
              end else begin
                part_cnt_nxt = 32'd0;
                if (fsz_r != 32'd0) begin
                  phase_nxt = PH_DATA;
                end else begin
                  entry_nxt = entry_r + 16'd1;
                  phase_nxt = PH_HEADER;
                end
              end
            end
          end
        end
        PH_NAME_PAD: begin
          if (off_nxt == 2'd0) begin
            part_cnt_nxt = 32'd0;
            if (fsz_r != 32'd0) begin
              phase_nxt = PH_DATA;
            end else begin
              entry_nxt = entry_r + 16'd1;
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_DATA: begin
          res_valid    = emit_data_r;
          res_kind     = KIND_DATA;
          res_byte     = b;
          res_last     = data_last;
          part_cnt_nxt = idx + 32'd1;
          if (data_last) begin
            if (off_nxt != 2'd0) begin
              phase_nxt = PH_DATA_PAD;
            end else begin
              part_cnt_nxt = 32'd0;
              entry_nxt    = entry_r + 16'd1;
              phase_nxt    = PH_HEADER;
            end
          end
        end
        PH_DATA_PAD: begin
          if (off_nxt == 2'd0) begin
            part_cnt_nxt = 32'd0;
            entry_nxt    = entry_r + 16'd1;
            phase_nxt    = PH_HEADER;
          end
        end
        default: begin
          // done or error: swallow bytes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      part_cnt_r   <= 32'd0;
      off_r        <= 2'd0;
      fsz_r        <= 32'd0;
      nsz_r        <= 32'd0;
      tmatch_r     <= 1'b1;
      entry_r      <= 16'd0;
      emit_names_r <= 1'b1;
      emit_data_r  <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      part_cnt_r <= part_cnt_nxt;
      off_r      <= off_nxt;
      fsz_r      <= fsz_nxt;
      nsz_r      <= nsz_nxt;
      tmatch_r   <= tmatch_nxt;
      entry_r    <= entry_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EMIT_NAMES: emit_names_r <= cfg_wdata;
          CFG_EMIT_DATA:  emit_data_r  <= cfg_wdata;
          default:        ;
        endcase
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_last_r  <= res_last;
      out_entry_r <= entry_r;
      out_fsz_r   <= fsz_nxt;
      out_nsz_r   <= nsz_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_kind     = out_kind_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.last_of_part = out_last_r;
  assign out_ch.entry_number = out_entry_r;
  assign out_ch.size_of_file = out_fsz_r;
  assign out_ch.size_of_name = out_nsz_r;

endmodule

// ===== src/cnad_checker.sv =====
`timescale 1ns / 1ps
module cnad_checker
  import cnad_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic        last_of_part,
  input logic [15:0] entry_number
);

  // a full, stalled output register is the only reason to refuse input
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input refused without a stalled output");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) &&
      $stable(out_byte) && $stable(entry_number)))
    else $error("stalled output item changed");

  // end marker and error are final: nothing follows
  a_terminal_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_kind == KIND_END || out_kind == KIND_ERROR))
      |=> !out_valid)
    else $error("item after end of archive or error");

  a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_END || out_kind == KIND_ERROR))
      |-> (out_byte == 8'd0 && !last_of_part))
    else $error("end or error item carries a byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind cpio_newc_archive_deframer cnad_checker u_cnad_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.out_kind),
  .out_byte     (out_ch.out_byte),
  .last_of_part (out_ch.last_of_part),
  .entry_number (out_ch.entry_number)
);

// ===== dv/cpio_newc_archive_deframer_test.sv =====
`timescale 1ns / 1ps
module cpio_newc_archive_deframer_test;
  import cnad_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_UNTIL = 560;

  localparam logic [47:0] MAGIC_TXT   = "070701";
  localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";

  typedef enum logic [2:0] {
    P_HEADER, P_NAME, P_NAME_PAD, P_DATA, P_DATA_PAD, P_DONE, P_ERROR
  } parse_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] entry;
    logic [31:0] fsize;
    logic [31:0] nsize;
  } deframe_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_wdata;

  cnad_in_if  in_ch();
  cnad_out_if out_ch();

  cpio_newc_archive_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // archive bytes waiting to be driven, results waiting to be seen
  logic [7:0]      archive_q[$];
  deframe_result_t pending_results[$];

  int cycle_count  = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int bytes_pushed = 0;
  int bytes_taken  = 0;
  bit in_accepted  = 1'b0;
  bit steady       = 1'b0;
  int in_gap       = 0;
  int stall_left   = 0;

  // parser state mirror
  parse_phase_t ph;
  logic [31:0]  part_idx;
  logic [1:0]   align_pos;
  logic [31:0]  fsize_acc;
  logic [31:0]  nsize_acc;
  logic         trailer_ok;
  logic [15:0]  entry_idx;
  logic         names_on;
  logic         data_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] magic_at(input int k);
    return MAGIC_TXT[8*(5-k) +: 8];
  endfunction

  function automatic logic [7:0] trailer_at(input int k);
    return TRAILER_TXT[8*(9-k) +: 8];
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - 48;
    if (b >= "a" && b <= "f") return int'(b) - 87;
    if (b >= "A" && b <= "F") return int'(b) - 55;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void note_result(input logic [1:0] kind, input logic [7:0] b,
                                      input logic last);
    deframe_result_t r;
    r.kind  = kind;
    r.data  = b;
    r.last  = last;
    r.entry = entry_idx;
    r.fsize = fsize_acc;
    r.nsize = nsize_acc;
    pending_results.push_back(r);
  endfunction

  function automatic void next_entry();
    entry_idx = entry_idx + 16'd1;
    part_idx  = '0;
    ph        = P_HEADER;
  endfunction

  function automatic void leave_data(input logic [1:0] off);
    if (off != 2'd0) ph = P_DATA_PAD;
    else next_entry();
  endfunction

  function automatic void begin_data(input logic [1:0] off);
    part_idx = '0;
    if (fsize_acc != '0) ph = P_DATA;
    else leave_data(off);
  endfunction

  function automatic void leave_name(input logic [1:0] off);
    if (off != 2'd0) ph = P_NAME_PAD;
    else begin_data(off);
  endfunction

  // advance the parser mirror by one accepted archive byte
  function automatic void parse_archive_byte(input logic [7:0] b);
    logic [1:0]  off;
    logic [31:0] idx;
    logic        bad;
    logic        last;
    int          h;
    off = align_pos + 2'd1;
    idx = part_idx;
    bad = 1'b0;
    case (ph)
      P_HEADER: begin
        if (idx == '0) begin
          fsize_acc  = '0;
          nsize_acc  = '0;
          trailer_ok = 1'b1;
        end
        if (idx < MAGIC_LEN) begin
          bad = (b != magic_at(int'(idx)));
        end else if (idx >= FSIZE_FIRST && idx <= FSIZE_LAST) begin
          h = hex_nibble(b);
          if (h < 0) bad = 1'b1;
          else fsize_acc = {fsize_acc[27:0], h[3:0]};
        end else if (idx >= NSIZE_FIRST && idx <= NSIZE_LAST) begin
          h = hex_nibble(b);
          if (h < 0) bad = 1'b1;
          else nsize_acc = {nsize_acc[27:0], h[3:0]};
        end
        if (bad) begin
          note_result(KIND_ERROR, 8'd0, 1'b0);
          ph = P_ERROR;
        end else if (idx + 32'd1 >= HDR_LEN) begin
          part_idx = '0;
          if (nsize_acc != '0) ph = P_NAME;
          else leave_name(off);
        end else begin
          part_idx = idx + 32'd1;
        end
      end
      P_NAME: begin
        last = (idx == nsize_acc - 32'd1);
        if (idx < TRAILER_LEN && b != trailer_at(int'(idx))) trailer_ok = 1'b0;
        if (idx == TRAILER_LEN - 32'd1 && trailer_ok) begin
          note_result(KIND_END, 8'd0, 1'b0);
          ph = P_DONE;
        end else begin
          if (names_on) note_result(KIND_NAME, b, last);
          part_idx = idx + 32'd1;
          if (last) leave_name(off);
        end
      end
      P_NAME_PAD: begin
        if (off == 2'd0) begin_data(off);
      end
      P_DATA: begin
        last = (idx == fsize_acc - 32'd1);
        if (data_on) note_result(KIND_DATA, b, last);
        part_idx = idx + 32'd1;
        if (last) leave_data(off);
      end
      P_DATA_PAD: begin
        if (off == 2'd0) next_entry();
      end
      default: ;
    endcase
    align_pos = off;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                              results_seen, field, got, want));
  endtask

  task automatic check_result();
    deframe_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind %0d byte %02h",
                              out_ch.out_kind, out_ch.out_byte));
    end else begin
      want = pending_results.pop_front();
      compare_field("out_kind", 32'(out_ch.out_kind), 32'(want.kind));
      compare_field("out_byte", 32'(out_ch.out_byte), 32'(want.data));
      compare_field("last_of_part", 32'(out_ch.last_of_part), 32'(want.last));
      compare_field("entry_number", 32'(out_ch.entry_number), 32'(want.entry));
      compare_field("size_of_file", out_ch.size_of_file, want.fsize);
      compare_field("size_of_name", out_ch.size_of_name, want.nsize);
    end
    results_seen++;
  endtask

  // monitor: sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    cycle_count++;
    if (!rst_n) begin
      ph         = P_HEADER;
      part_idx   = '0;
      align_pos  = '0;
      fsize_acc  = '0;
      nsize_acc  = '0;
      trailer_ok = 1'b1;
      entry_idx  = '0;
      names_on   = 1'b1;
      data_on    = 1'b1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_archive_byte(in_ch.in_byte);
        bytes_taken++;
        in_accepted = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_we) begin
        case (cfg_index)
          CFG_EMIT_NAMES: names_on = cfg_wdata;
          CFG_EMIT_DATA:  data_on  = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_accepted)) begin
      in_accepted = 1'b0;
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap--;
      end else if (archive_q.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= archive_q.pop_front();
        in_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink; also flips between gappy and gap-free stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) steady = !steady;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic push_byte(input logic [7:0] b);
    archive_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_pad();
    while (bytes_pushed % 4 != 0) push_byte(8'($urandom_range(0, 255)));
  endtask

  // bad_at < 0: clean header; otherwise that byte is corrupted
  task automatic push_header(input logic [31:0] fsize, input logic [31:0] nsize,
                             input int bad_at);
    logic [7:0] b;
    for (int i = 0; i < int'(HDR_LEN); i++) begin
      if (i < int'(MAGIC_LEN)) b = magic_at(i);
      else if (i >= int'(FSIZE_FIRST) && i <= int'(FSIZE_LAST))
        b = hex_char(fsize[4*(int'(FSIZE_LAST) - i) +: 4]);
      else if (i >= int'(NSIZE_FIRST) && i <= int'(NSIZE_LAST))
        b = hex_char(nsize[4*(int'(NSIZE_LAST) - i) +: 4]);
      else b = 8'($urandom_range(0, 255));
      if (i == bad_at) begin
        do b = 8'($urandom_range(0, 255));
        while (i < int'(MAGIC_LEN) ? b == magic_at(i) : hex_nibble(b) >= 0);
      end
      push_byte(b);
    end
  endtask

  task automatic push_entry(input logic [31:0] fsize, input logic [31:0] nsize,
                            input string head);
    push_header(fsize, nsize, -1);
    for (int k = 0; k < int'(nsize); k++)
      push_byte(k < head.len() ? 8'(head[k]) : 8'($urandom_range(0, 255)));
    push_pad();
    for (int k = 0; k < int'(fsize); k++) push_byte(8'($urandom_range(0, 255)));
    push_pad();
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_pushed || pending_results.size() != 0) @(negedge clk);
    // a byte that makes no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_emission(input logic names, input logic data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EMIT_NAMES;
    cfg_wdata <= names;
    @(negedge clk);
    cfg_index <= CFG_EMIT_DATA;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int          r;
    logic [31:0] nlen;
    logic [31:0] flen;
    string       head;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_EMIT_NAMES;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    out_ch.ready  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty name and data, near-miss trailer names, silent emission
    push_entry(32'd0, 32'd0, "");
    push_entry(32'd1, 32'd9, "TRAILER!!");
    set_emission(1'b0, 1'b0);
    push_entry(32'd4, 32'd10, "TRAILER!!X");
    set_emission(1'b1, 1'b1);

    while (bytes_pushed < RANDOM_UNTIL) begin
      if ($urandom_range(0, 2) == 0)
        set_emission(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      nlen = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      r = $urandom_range(0, 99);
      flen = (r < 10) ? 0 : (r < 75) ? $urandom_range(1, 24) :
             (r < 95) ? $urandom_range(25, 100) : $urandom_range(101, 300);
      case ($urandom_range(0, 7))
        0: head = "T";
        1: head = "TRAIL";
        2: head = "TRAILER!!x";
        default: head = "";
      endcase
      push_entry(flen, nlen, head);
    end

    // the archive ends once: trailer, bad magic, or a bad digit in either size
    case ($urandom_range(0, 3))
      0: begin
        if ($urandom_range(0, 1)) push_header('1, '1, -1);
        else push_header($urandom_range(0, 40), $urandom_range(10, 13), -1);
        for (int k = 0; k < int'(TRAILER_LEN); k++) push_byte(trailer_at(k));
      end
      1: push_header($urandom, $urandom, $urandom_range(0, int'(MAGIC_LEN) - 1));
      2: push_header('1, '1, $urandom_range(int'(FSIZE_FIRST), int'(FSIZE_LAST)));
      default: push_header('1, $urandom, $urandom_range(int'(NSIZE_FIRST), int'(NSIZE_LAST)));
    endcase
    // swallowed after the stop
    repeat (24) push_byte(8'($urandom_range(0, 255)));

    wait_idle();
    repeat (16) @(negedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cnad_pkg.sv
src/cnad_if.sv
src/cpio_newc_archive_deframer.sv
src/cnad_checker.sv
dv/cpio_newc_archive_deframer_test.sv
